### rtl/core/sjhp_pkg.sv
// Shared types and constants for the hash-join probe block.
// No dependencies.
package sjhp_pkg;
	localparam int NumTables = 4;
	localparam int SlotBits = 10;
	localparam int TabBits = 2;
	localparam int AddrBits = TabBits + SlotBits;
	localparam int StoreDepth = NumTables << SlotBits;
	localparam logic [31:0] EmptyKey = 32'hFFFF_FFFF;

	localparam logic [2:0] CfgFactor = 3'd0;
	localparam logic [2:0] CfgTables = 3'd1;
	localparam logic [2:0] CfgSlotBits = 3'd2;
	localparam logic [2:0] CfgShift0 = 3'd3;
	localparam logic [2:0] CfgShift1 = 3'd4;
	localparam logic [2:0] CfgShift2 = 3'd5;
	localparam logic [2:0] CfgShift3 = 3'd6;

	localparam logic CmdWrite = 1'b0;
	localparam logic CmdProbe = 1'b1;

	// controller -> datapath
	typedef struct packed {
		logic load;      // capture input item
		logic wr;        // write key/payload store at captured slot
		logic clr;       // clearing pass write at clr address
		logic hash;      // start multiply for current table
		logic start;     // compute start slot from product
		logic rd;        // issue store read at walk address
		logic step;      // advance walk address
		logic keep;      // latch matched payload for current table
		logic next_tab;  // advance to next table
		logic emit;      // load output register
	} sjhp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_probe;
		logic is_empty;
		logic is_match;
		logic walk_done;
		logic last_tab;
		logic clr_done;
	} sjhp_sts_t;
endpackage

### rtl/core/star_join_hash_probe.sv
// Top level of the hash-join probe block: stream ports, controller, datapath.
// Depends on sjhp_pkg, sjhp_ctrl and sjhp_datapath.
//
// A write item passes through decode and back to idle. A probe item passes,
// per table joined, through hash and start-slot setup and then, per slot
// visited on the single store read port, through read, registered data and
// compare; it begins with decode and ends in the idle state, in which the
// next item is taken. After reset a clearing pass marks all 4096 key slots
// empty, one per cycle, before the first item is taken (configuration
// writes are taken during it). A result waits in an output register and no
// item is taken while it waits, so a probe with a result holds off the next
// item until m_tready is seen high.
module star_join_hash_probe (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	// command, table_index, slot_index, entry_key, entry_payload,
	// key_0..key_3, fact_payload, zero pad
	input  logic [239:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// match_payload_0..3, fact_payload_out
	output logic [159:0] m_tdata
);
	import sjhp_pkg::*;

	sjhp_cmd_t cmd;
	sjhp_sts_t sts;
	logic ctrl_rdy, in_fire;

	// hold input while a result is still waiting, so results never collide
	assign s_tready = ctrl_rdy && !m_tvalid;
	assign in_fire = s_tvalid && s_tready;

	sjhp_ctrl u_ctrl (
		.clk, .arst_n, .in_fire, .in_rdy(ctrl_rdy),
		.out_vld(m_tvalid), .out_rdy(m_tready), .sts, .cmd
	);

	sjhp_datapath u_dp (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.in_data(s_tdata[236:0]), .cmd, .sts, .out_data(m_tdata)
	);
endmodule

### rtl/core/sjhp_datapath.sv
// Datapath: config registers, key/payload stores, hash unit, walk counter.
// Depends on sjhp_pkg.
module sjhp_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [2:0]           cfg_index,
	input  logic [31:0]          cfg_data,
	input  logic [236:0]         in_data,
	input  sjhp_pkg::sjhp_cmd_t  cmd,
	output sjhp_pkg::sjhp_sts_t  sts,
	output logic [159:0]         out_data
);
	import sjhp_pkg::*;

	logic [31:0] factor_q;
	logic [2:0]  tables_q;
	logic [3:0]  sbits_q;
	logic [4:0]  shift_q [NumTables];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			factor_q <= 32'd2654435761;
			tables_q <= 3'd1;
			sbits_q  <= 4'd10;
			for (int i = 0; i < NumTables; i++) shift_q[i] <= 5'd22;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CfgFactor:   factor_q <= cfg_data;
				CfgTables:   tables_q <= cfg_data[2:0];
				CfgSlotBits: sbits_q <= cfg_data[3:0];
				CfgShift0:   shift_q[0] <= cfg_data[4:0];
				CfgShift1:   shift_q[1] <= cfg_data[4:0];
				CfgShift2:   shift_q[2] <= cfg_data[4:0];
				CfgShift3:   shift_q[3] <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// effective table count and slot mask
	logic [2:0] ntab;
	logic [3:0] sb;
	logic [SlotBits-1:0] mask;
	always_comb begin
		ntab = tables_q;
		if (ntab == 3'd0) ntab = 3'd1;
		if (ntab > 3'(NumTables)) ntab = 3'(NumTables);
		sb = sbits_q;
		if (sb == 4'd0) sb = 4'd1;
		if (sb > 4'(SlotBits)) sb = 4'(SlotBits);
		mask = SlotBits'((11'd1 << sb) - 11'd1);
	end

	// captured item
	logic        probe_q;
	logic [1:0]  wtab_q;
	logic [9:0]  wslot_q;
	logic [31:0] wkey_q, wpay_q, fact_q;
	logic [31:0] key_q [NumTables];
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			probe_q <= in_data[0];
			wtab_q  <= in_data[2:1];
			wslot_q <= in_data[12:3];
			wkey_q  <= in_data[44:13];
			wpay_q  <= in_data[76:45];
			for (int i = 0; i < NumTables; i++) key_q[i] <= in_data[77+32*i +: 32];
			fact_q  <= in_data[236:205];
		end
	end

	// walk state
	logic [TabBits-1:0]  tab_q;
	logic [SlotBits-1:0] pos_q;
	logic [SlotBits:0]   cnt_q;
	logic [31:0]         prod_q;
	logic [AddrBits:0]   clr_q;
	logic [31:0]         cur_key;
	assign cur_key = key_q[tab_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_q <= '0;
		else if (cmd.clr) clr_q <= clr_q + 1'b1;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) tab_q <= '0;
		else if (cmd.next_tab) tab_q <= tab_q + 1'b1;
		if (cmd.hash) prod_q <= cur_key * factor_q;
		if (cmd.start) begin
			pos_q <= SlotBits'(prod_q >> shift_q[tab_q]) & mask;
			cnt_q <= '0;
		end else if (cmd.step) begin
			pos_q <= (pos_q + 1'b1) & mask;
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// stores, one write port, one registered read
	logic [31:0] kmem [StoreDepth];
	logic [31:0] pmem [StoreDepth];
	logic [31:0] krd_q, prd_q;
	logic [AddrBits-1:0] waddr;
	logic [31:0] wk;
	assign waddr = cmd.clr ? clr_q[AddrBits-1:0] : {wtab_q, wslot_q};
	assign wk = cmd.clr ? EmptyKey : wkey_q;
	always_ff @(posedge clk) begin
		if (cmd.wr || cmd.clr) kmem[waddr] <= wk;
		if (cmd.wr) pmem[waddr] <= wpay_q;
		if (cmd.rd) begin
			krd_q <= kmem[{tab_q, pos_q}];
			prd_q <= pmem[{tab_q, pos_q}];
		end
	end

	// the last table's payload is kept in the same cycle as the emit, so take
	// it straight from the read data
	logic [31:0] pay_q [NumTables];
	always_ff @(posedge clk) begin
		if (cmd.load)
			for (int i = 0; i < NumTables; i++) pay_q[i] <= '0;
		else if (cmd.keep) pay_q[tab_q] <= prd_q;
		if (cmd.emit) begin
			for (int i = 0; i < NumTables; i++)
				out_data[32*i +: 32] <= (cmd.keep && tab_q == TabBits'(i)) ? prd_q : pay_q[i];
			out_data[159:128] <= fact_q;
		end
	end

	assign sts.is_probe  = probe_q;
	assign sts.is_empty  = krd_q == EmptyKey;
	assign sts.is_match  = krd_q == cur_key;
	assign sts.walk_done = cnt_q == ((SlotBits+1)'(1) << sb) - 1'b1;
	assign sts.last_tab  = 3'(tab_q) + 3'd1 >= ntab;
	assign sts.clr_done  = clr_q[AddrBits];
endmodule

### rtl/core/sjhp_ctrl.sv
// Controller state machine for the clearing pass, item decode, probe walk and output handshake.
// Depends on sjhp_pkg.
module sjhp_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_fire,
	output logic                 in_rdy,
	output logic                 out_vld,
	input  logic                 out_rdy,
	input  sjhp_pkg::sjhp_sts_t  sts,
	output sjhp_pkg::sjhp_cmd_t  cmd
);
	import sjhp_pkg::*;

	typedef enum logic [2:0] {
		ST_CLEAR, ST_IDLE, ST_DECODE, ST_HASH, ST_START, ST_READ, ST_WAIT, ST_TEST
	} state_t;
	state_t state_q;
	logic   ovld_q;
	logic   emit;

	assign out_vld = ovld_q;
	assign in_rdy = state_q == ST_IDLE;
	assign emit = state_q == ST_TEST && !sts.is_empty && sts.is_match && sts.last_tab;

	always_comb begin
		cmd = '0;
		cmd.load = in_fire;
		cmd.clr = state_q == ST_CLEAR;
		cmd.wr = state_q == ST_DECODE && !sts.is_probe;
		cmd.hash = state_q == ST_HASH;
		cmd.start = state_q == ST_START;
		cmd.rd = state_q == ST_READ;
		if (state_q == ST_TEST && !sts.is_empty) begin
			if (sts.is_match) begin
				cmd.keep = 1'b1;
				cmd.next_tab = !sts.last_tab;
			end else begin
				cmd.step = 1'b1;
			end
		end
		cmd.emit = emit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			ovld_q <= 1'b0;
		end else begin
			if (emit) ovld_q <= 1'b1;
			else if (out_rdy) ovld_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR:  if (sts.clr_done) state_q <= ST_IDLE;
				ST_IDLE:   if (in_fire) state_q <= ST_DECODE;
				ST_DECODE: state_q <= sts.is_probe ? ST_HASH : ST_IDLE;
				ST_HASH:   state_q <= ST_START;
				ST_START:  state_q <= ST_READ;
				ST_READ:   state_q <= ST_WAIT;
				ST_WAIT:   state_q <= ST_TEST;
				ST_TEST: begin
					if (sts.is_empty) state_q <= ST_IDLE;
					else if (sts.is_match) state_q <= sts.last_tab ? ST_IDLE : ST_HASH;
					else if (sts.walk_done) state_q <= ST_IDLE;
					else state_q <= ST_READ;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
